// ===== hw/rtl/rle_voxel_slice_decoder_defines.svh =====
// assertion macros for the run-length voxel slice decoder
`ifndef RLE_VOXEL_SLICE_DECODER_DEFINES_SVH
`define RLE_VOXEL_SLICE_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define RVSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`define RVSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`else

`define RVSD_ASSERT(lbl, prop, msg)

`define RVSD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== hw/rtl/rvsd_pkg.sv =====
// shared constants, types and helpers of the run-length voxel slice decoder
package rvsd_pkg;

  localparam int MaxDim   = 1024;
  localparam int DimCap   = (MaxDim < 1024) ? MaxDim : 1024;
  localparam int YTop     = DimCap - 1;

  localparam int PosW     = 10;
  localparam int DimW     = 11;
  localparam int LenW     = 21;
  localparam int WordW    = 32;
  localparam int ChanW    = 8;
  localparam int CfgIdxW  = 3;
  localparam int DivSteps = LenW;
  localparam int DivCntW  = $clog2(DivSteps + 1);
  localparam int OutDataW = 88;

  localparam logic [LenW-1:0]  RunCap       = LenW'(1048576);
  localparam logic [WordW-1:0] WordRun      = WordW'(2);
  localparam logic [WordW-1:0] WordSliceEnd = WordW'(6);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COLOR_ORDER = 3'd0,
    CFG_RUN_CODED   = 3'd1,
    CFG_WIDTH_X     = 3'd2,
    CFG_HEIGHT_Y    = 3'd3,
    CFG_DEPTH_Z     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic            start;
    logic [LenW-1:0] dividend;
    logic [DimW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [LenW-1:0] quot;
    logic [PosW-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic [ChanW-1:0] alpha;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
    logic [LenW-1:0]  run_length;
    logic [PosW-1:0]  pos_z;
    logic [PosW-1:0]  pos_y;
    logic [PosW-1:0]  pos_x;
  } result_t;

  function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > DimW'(DimCap)) begin
      r = DimW'(DimCap);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/rvsd_div.sv =====
// serial restoring divider, one quotient bit per cycle
module rvsd_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rvsd_pkg::div_req_t req_i,
  output rvsd_pkg::div_rsp_t rsp_o
);
  import rvsd_pkg::*;

  typedef enum logic {
    DIV_IDLE,
    DIV_RUN
  } div_state_e;

  div_state_e         state_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DimW-1:0]    rem_q, rem_d;
  logic [LenW-1:0]    quo_q, quo_d;
  logic [DimW-1:0]    dvs_q;
  logic               done_q;

  logic [DimW:0]      trial;
  logic               fits;

  always_comb begin
    trial = {rem_q, quo_q[LenW-1]};
    fits  = trial >= {1'b0, dvs_q};
    rem_d = fits ? DimW'(trial - {1'b0, dvs_q}) : trial[DimW-1:0];
    quo_d = {quo_q[LenW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      dvs_q   <= DimW'(1);
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        DIV_IDLE: begin
          if (req_i.start) begin
            rem_q   <= '0;
            quo_q   <= req_i.dividend;
            dvs_q   <= req_i.divisor;
            cnt_q   <= DivCntW'(DivSteps);
            state_q <= DIV_RUN;
          end
        end
        DIV_RUN: begin
          rem_q <= rem_d;
          quo_q <= quo_d;
          cnt_q <= cnt_q - DivCntW'(1);
          if (cnt_q == DivCntW'(1)) begin
            done_q  <= 1'b1;
            state_q <= DIV_IDLE;
          end
        end
        default: state_q <= DIV_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q[PosW-1:0];

endmodule

// ===== hw/rtl/rle_voxel_slice_decoder.sv =====
// top level of the run-length voxel slice decoder
// Usage:
//   s_axis_* takes one 32-bit word of voxel data per request. m_axis_* gives one
//   run descriptor per request: start x, y, z, run length and the unpacked color.
//   Words with a zero alpha byte and code words give no descriptor.
//   cfg_* writes the color order, coding mode and matrix sizes by register index;
//   always ready; the user must write it only while the decoder is idle; not enforced.
// Input flow:
//   count, run-code and slice-end words leave s_axis ready for the next word; a raw-mode
//   word does too, unless it gives a descriptor: the staging register blocks s_axis.
//   a single voxel or a run color word with a nonzero count blocks s_axis while
//   the cursor advance runs through a 21-step serial divider by width_x.
//   a taken word's descriptor passes the staging register, then the output register.
// Reset:
//   cursor, phase and pending count clear; sizes return to 16, mode to run-length.
// Stall:
//   every descriptor passes a staging register that blocks s_axis until the output
//   register takes it; a stalled receiver holds one descriptor in each and stops input.
`include "rle_voxel_slice_decoder_defines.svh"

module rle_voxel_slice_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rvsd_pkg::WordW-1:0]    s_axis_tdata,   // word
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // pos_x, pos_y, pos_z, run_length, red, green, blue, alpha, zero fill
  output logic [rvsd_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rvsd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rvsd_pkg::DimW-1:0]     cfg_data_i
);
  import rvsd_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_e;

  typedef enum logic [1:0] {
    PH_CODE,
    PH_COUNT,
    PH_COLOR
  } phase_e;

  state_e          state_q;
  phase_e          phase_q;
  logic            color_order_q;
  logic            run_coded_q;
  logic [DimW-1:0] width_x_q, height_y_q, depth_z_q;
  logic [PosW-1:0] col_q, row_q, slice_q;
  logic [LenW-1:0] pending_q;
  result_t         res_q, out_q;
  logic            pend_q, out_valid_q;

  div_req_t        div_req;
  div_rsp_t        div_rsp;

  logic            acc;
  logic [WordW-1:0] w;
  logic            alpha_nz;
  logic [DimW-1:0] wx, hy, dz;
  logic            do_emit, do_div, do_raw, do_slice, do_count, do_color;
  logic [LenW-1:0] emit_len, div_n;
  logic [DimW-1:0] col_inc, row_inc, slice_inc;
  logic [LenW:0]   row_sum;
  logic [LenW-1:0] count_clip;
  logic            out_free;
  result_t         res_d;

  assign w        = s_axis_tdata;
  assign acc      = s_axis_tvalid && s_axis_tready;
  assign alpha_nz = |w[WordW-1:WordW-ChanW];
  assign wx       = clamp_dim(width_x_q);
  assign hy       = clamp_dim(height_y_q);
  assign dz       = clamp_dim(depth_z_q);

  assign col_inc    = {1'b0, col_q} + DimW'(1);
  assign row_inc    = {1'b0, row_q} + DimW'(1);
  assign slice_inc  = {1'b0, slice_q} + DimW'(1);
  assign count_clip = (w > {11'b0, RunCap}) ? RunCap : w[LenW-1:0];
  assign row_sum    = {1'b0, div_rsp.quot} + (LenW+1)'(row_q);

  always_comb begin
    do_emit  = 1'b0;
    do_div   = 1'b0;
    do_raw   = 1'b0;
    do_slice = 1'b0;
    do_count = 1'b0;
    do_color = 1'b0;
    emit_len = LenW'(1);
    div_n    = LenW'(1);
    if (!run_coded_q) begin
      do_raw  = 1'b1;
      do_emit = alpha_nz;
    end else begin
      unique case (phase_q)
        PH_COUNT: do_count = 1'b1;
        PH_COLOR: begin
          do_color = 1'b1;
          if (pending_q != '0) begin
            do_emit  = alpha_nz;
            emit_len = pending_q;
            do_div   = 1'b1;
            div_n    = pending_q;
          end
        end
        default: begin
          if (w == WordSliceEnd) begin
            do_slice = 1'b1;
          end else if (w != WordRun) begin
            do_emit = alpha_nz;
            do_div  = 1'b1;
          end
        end
      endcase
    end
  end

  always_comb begin
    res_d.pos_x      = col_q;
    res_d.pos_y      = row_q;
    res_d.pos_z      = slice_q;
    res_d.run_length = emit_len;
    res_d.red        = color_order_q ? w[23:16] : w[7:0];
    res_d.green      = w[15:8];
    res_d.blue       = color_order_q ? w[7:0] : w[23:16];
    res_d.alpha      = w[31:24];
  end

  assign div_req.start    = acc && do_div;
  assign div_req.dividend = (LenW'(col_q)) + div_n;
  assign div_req.divisor  = wx;

  rvsd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && !pend_q;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      phase_q       <= PH_CODE;
      color_order_q <= 1'b0;
      run_coded_q   <= 1'b1;
      width_x_q     <= DimW'(16);
      height_y_q    <= DimW'(16);
      depth_z_q     <= DimW'(16);
      col_q         <= '0;
      row_q         <= '0;
      slice_q       <= '0;
      pending_q     <= '0;
      res_q         <= '0;
      out_q         <= '0;
      pend_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_COLOR_ORDER: color_order_q <= cfg_data_i[0];
          CFG_RUN_CODED:   run_coded_q   <= cfg_data_i[0];
          CFG_WIDTH_X:     width_x_q     <= cfg_data_i;
          CFG_HEIGHT_Y:    height_y_q    <= cfg_data_i;
          CFG_DEPTH_Z:     depth_z_q     <= cfg_data_i;
          default: ;
        endcase
      end

      if (pend_q && out_free) begin
        out_q       <= res_q;
        out_valid_q <= 1'b1;
        pend_q      <= 1'b0;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (acc) begin
            if (do_emit) begin
              res_q  <= res_d;
              pend_q <= 1'b1;
            end
            if (do_raw) begin
              phase_q <= PH_CODE;
              if (col_inc >= wx) begin
                col_q <= '0;
                if (row_inc >= hy) begin
                  row_q <= '0;
                  slice_q <= (slice_inc >= dz) ? '0 : slice_inc[PosW-1:0];
                end else begin
                  row_q <= row_inc[PosW-1:0];
                end
              end else begin
                col_q <= col_inc[PosW-1:0];
              end
            end else if (do_count) begin
              pending_q <= count_clip;
              phase_q   <= PH_COLOR;
            end else if (do_color) begin
              pending_q <= '0;
              phase_q   <= PH_CODE;
            end else if (do_slice) begin
              col_q   <= '0;
              row_q   <= '0;
              slice_q <= (slice_inc >= dz) ? '0 : slice_inc[PosW-1:0];
              phase_q <= PH_CODE;
            end else if (do_div) begin
              phase_q <= PH_CODE;
            end else begin
              phase_q <= PH_COUNT;
            end
            if (do_div) begin
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            col_q   <= div_rsp.rem;
            row_q   <= (row_sum > (LenW+1)'(YTop)) ? PosW'(YTop) : row_sum[PosW-1:0];
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_q};

  `RVSD_ASSERT(a_done_in_div, div_rsp.done |-> state_q == ST_DIV, "divider done while idle")
  `RVSD_ASSERT(a_done_to_idle, div_rsp.done |=> state_q == ST_IDLE, "no return to idle")
  `RVSD_ASSERT(a_pend_blocks, pend_q |-> !s_axis_tready, "input taken with staged result")
  `RVSD_ASSERT_ALWAYS(a_reset_out, !rst_ni |=> !m_axis_tvalid, "output valid in reset")

endmodule
